### rtl/trie_prefix_count_core_macros.svh
// Assertion macros shared by the checker of the trie prefix counter.
// Self-contained; included by the checker file only.
`ifndef TRIE_PREFIX_COUNT_CORE_MACROS_SVH
`define TRIE_PREFIX_COUNT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tpc checker: same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define TPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tpc checker: next-cycle implication failed");

`endif

### rtl/tpc_pkg.sv
// Package for the trie prefix counter: sizes, codes and the byte-to-symbol map.
// No dependencies.
package tpc_pkg;

    localparam int NODE_CAPACITY = 4096;
    localparam int SYMBOLS       = 64;
    localparam int NODE_W        = $clog2(NODE_CAPACITY);
    localparam int SYM_W         = $clog2(SYMBOLS);
    localparam int CHILD_DEPTH   = NODE_CAPACITY * SYMBOLS;
    localparam int CHILD_AW      = $clog2(CHILD_DEPTH);
    localparam int COUNT_W       = 32;

    localparam logic [7:0] SYM_INVALID = 8'hFF;

    // ASCII bounds of the three symbol ranges.
    localparam logic [7:0] CHR_0 = 8'h30;
    localparam logic [7:0] CHR_9 = 8'h39;
    localparam logic [7:0] CHR_A = 8'h41;
    localparam logic [7:0] CHR_Z = 8'h5A;
    localparam logic [7:0] CHR_a = 8'h61;
    localparam logic [7:0] CHR_z = 8'h7A;
    localparam logic [7:0] UPPER_BASE = 8'd10;
    localparam logic [7:0] LOWER_BASE = 8'd36;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BADCHAR = 2'd2
    } t_status;

    // Digits first, then upper case, then lower case; anything else is invalid.
    function automatic logic [7:0] tpc_sym_of(input logic [7:0] b);
        logic [7:0] s;
        s = SYM_INVALID;
        if (b >= CHR_0 && b <= CHR_9) begin
            s = b - CHR_0;
        end else if (b >= CHR_A && b <= CHR_Z) begin
            s = b - CHR_A + UPPER_BASE;
        end else if (b >= CHR_a && b <= CHR_z) begin
            s = b - CHR_a + LOWER_BASE;
        end
        return s;
    endfunction

endpackage

### rtl/trie_prefix_count_core.sv
// Top level of the trie prefix counter: walk sequencer around two node memories.
// Depends on tpc_pkg and tpc_ram.
//
//   Channel  Direction  Handshake                 Beat contents
//   input    in         start high, busy low      i_operation, i_char_byte, i_last_char
//   result   out        o_result_strobe, 1 cycle  o_done_operation, o_prefix_matches,
//                                                 o_status
//
// A byte that does not walk (the walk already stopped, or a non-alphanumeric byte)
// is taken in IDLE alone. A walking insert byte passes LOOKUP; a walking query byte
// passes LOOKUP, then QSUM (LOOKUP alone when the child is missing): the child-table
// read, then the count read of the child node. A last byte adds FINAL, and an insert
// with ST_OK status adds INCR: its end count is read in FINAL, raised and written back.
// After reset the block sweeps both memories clear, one child entry a cycle, over all
// CHILD_DEPTH entries (262144 at the default sizes), and holds busy high meanwhile.
// The result receiver cannot stall: each result beat is shown for one cycle only.
module trie_prefix_count_core
    import tpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_operation,
    input  logic [7:0]         i_char_byte,
    input  logic               i_last_char,
    output logic               o_result_strobe,
    output logic               o_done_operation,
    output logic [COUNT_W-1:0] o_prefix_matches,
    output logic [1:0]         o_status
);

    // CLEAR sweeps the memories, LOOKUP sees the child entry, QSUM sees the end
    // count of the child, FINAL closes a string and INCR writes the raised count.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_QSUM,
        S_FINAL,
        S_INCR
    } t_state;

    t_state               r_state, n_state;
    logic                 r_op, n_op;
    logic                 r_last, n_last;
    logic [SYM_W-1:0]     r_sym, n_sym;
    logic [NODE_W-1:0]    r_cur, n_cur;
    logic [NODE_W-1:0]    r_used, n_used;
    logic [COUNT_W-1:0]   r_sum, n_sum;
    logic                 r_stopped, n_stopped;
    t_status              r_status, n_status;
    logic [CHILD_AW-1:0]  r_clr, n_clr;
    logic                 r_strobe, n_strobe;
    logic                 r_done_op, n_done_op;
    logic [COUNT_W-1:0]   r_matches, n_matches;
    t_status              r_res_status, n_res_status;

    // Memory ports.
    logic                 child_we, child_re;
    logic [CHILD_AW-1:0]  child_waddr, child_raddr;
    logic [NODE_W-1:0]    child_wdata, child_rdata;
    logic                 cnt_we, cnt_re;
    logic [NODE_W-1:0]    cnt_waddr, cnt_raddr;
    logic [COUNT_W-1:0]   cnt_wdata, cnt_rdata;

    logic [7:0]           sym_code;
    logic                 sym_ok;
    logic [CHILD_AW-1:0]  idx_new, idx_held;
    logic [COUNT_W:0]     sum_wide;

    assign sym_code = tpc_sym_of(i_char_byte);
    assign sym_ok   = (sym_code != SYM_INVALID) && (sym_code < 8'(SYMBOLS));

    // Child entry of the current node: for a fresh byte and for the held one.
    assign idx_new  = CHILD_AW'(r_cur) * CHILD_AW'(SYMBOLS) + CHILD_AW'(sym_code[SYM_W-1:0]);
    assign idx_held = CHILD_AW'(r_cur) * CHILD_AW'(SYMBOLS) + CHILD_AW'(r_sym);

    assign sum_wide = {1'b0, r_sum} + {1'b0, cnt_rdata};

    tpc_ram #(
        .DEPTH (CHILD_DEPTH),
        .WIDTH (NODE_W)
    ) u_child_ram (
        .i_clk   (i_clk),
        .i_we    (child_we),
        .i_waddr (child_waddr),
        .i_wdata (child_wdata),
        .i_re    (child_re),
        .i_raddr (child_raddr),
        .o_rdata (child_rdata)
    );

    tpc_ram #(
        .DEPTH (NODE_CAPACITY),
        .WIDTH (COUNT_W)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (cnt_re),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_last       = r_last;
        n_sym        = r_sym;
        n_cur        = r_cur;
        n_used       = r_used;
        n_sum        = r_sum;
        n_stopped    = r_stopped;
        n_status     = r_status;
        n_clr        = r_clr;
        n_strobe     = 1'b0;
        n_done_op    = r_done_op;
        n_matches    = r_matches;
        n_res_status = r_res_status;

        child_we    = 1'b0;
        child_waddr = idx_held;
        child_wdata = '0;
        child_re    = 1'b0;
        child_raddr = idx_new;
        cnt_we      = 1'b0;
        cnt_waddr   = r_cur;
        cnt_wdata   = '0;
        cnt_re      = 1'b0;
        cnt_raddr   = r_cur;

        unique case (r_state)
            S_CLEAR: begin
                // Both memories are cleared in the same sweep; the count memory
                // is covered by the first NODE_CAPACITY steps.
                child_we    = 1'b1;
                child_waddr = r_clr;
                cnt_we      = (r_clr < CHILD_AW'(NODE_CAPACITY));
                cnt_waddr   = r_clr[NODE_W-1:0];
                if (r_clr == CHILD_AW'(CHILD_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end

            S_IDLE: begin
                if (start) begin
                    n_op   = i_operation;
                    n_last = i_last_char;
                    n_sym  = sym_code[SYM_W-1:0];
                    if (!r_stopped && sym_ok) begin
                        child_re = 1'b1;
                        n_state  = S_LOOKUP;
                    end else begin
                        if (!r_stopped) begin
                            n_stopped = 1'b1;
                            if (r_status == ST_OK) begin
                                n_status = ST_BADCHAR;
                            end
                        end
                        if (i_last_char) begin
                            n_state = S_FINAL;
                        end
                    end
                end
            end

            S_LOOKUP: begin
                n_state = r_last ? S_FINAL : S_IDLE;
                if (r_op == OP_INSERT) begin
                    if (child_rdata == '0) begin
                        if (r_used >= NODE_W'(NODE_CAPACITY - 1)) begin
                            n_stopped = 1'b1;
                            if (r_status == ST_OK) begin
                                n_status = ST_FULL;
                            end
                        end else begin
                            // Allocate the next free node and link it in.
                            n_used      = r_used + 1'b1;
                            n_cur       = n_used;
                            child_we    = 1'b1;
                            child_wdata = n_used;
                        end
                    end else begin
                        n_cur = child_rdata;
                    end
                end else begin
                    if (child_rdata == '0) begin
                        n_stopped = 1'b1;
                    end else begin
                        n_cur     = child_rdata;
                        cnt_re    = 1'b1;
                        cnt_raddr = child_rdata;
                        n_state   = S_QSUM;
                    end
                end
            end

            S_QSUM: begin
                n_sum   = sum_wide[COUNT_W] ? '1 : sum_wide[COUNT_W-1:0];
                n_state = r_last ? S_FINAL : S_IDLE;
            end

            S_FINAL: begin
                if (r_op == OP_INSERT && r_status == ST_OK) begin
                    cnt_re  = 1'b1;
                    n_state = S_INCR;
                end else begin
                    n_strobe     = 1'b1;
                    n_done_op    = r_op;
                    n_matches    = (r_op == OP_QUERY) ? r_sum : '0;
                    n_res_status = r_status;
                    n_cur        = '0;
                    n_sum        = '0;
                    n_stopped    = 1'b0;
                    n_status     = ST_OK;
                    n_state      = S_IDLE;
                end
            end

            S_INCR: begin
                // The count write lands before any later read, as the next string must pass
                // through IDLE before it reaches a count read.
                cnt_we       = 1'b1;
                cnt_wdata    = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 1'b1;
                n_strobe     = 1'b1;
                n_done_op    = r_op;
                n_matches    = '0;
                n_res_status = r_status;
                n_cur        = '0;
                n_sum        = '0;
                n_stopped    = 1'b0;
                n_status     = ST_OK;
                n_state      = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_cur     <= '0;
            r_used    <= '0;
            r_sum     <= '0;
            r_stopped <= 1'b0;
            r_status  <= ST_OK;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_cur     <= n_cur;
            r_used    <= n_used;
            r_sum     <= n_sum;
            r_stopped <= n_stopped;
            r_status  <= n_status;
            r_strobe  <= n_strobe;
        end
        r_op         <= n_op;
        r_last       <= n_last;
        r_sym        <= n_sym;
        r_done_op    <= n_done_op;
        r_matches    <= n_matches;
        r_res_status <= n_res_status;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_result_strobe  = r_strobe;
    assign o_done_operation = r_done_op;
    assign o_prefix_matches = r_matches;
    assign o_status         = r_res_status;

endmodule

### rtl/tpc_ram.sv
// Generic simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module tpc_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/tpc_checker.sv
// Port-level checker for the trie prefix counter, bound to the top level.
// Depends on tpc_pkg and trie_prefix_count_core_macros.svh.
`include "trie_prefix_count_core_macros.svh"

module tpc_checker
    import tpc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_result_strobe,
    input logic               o_done_operation,
    input logic [COUNT_W-1:0] o_prefix_matches
);

    // A result only follows work in progress.
    `TPC_ASSERT_IMP(a_strobe_after_busy, i_clk, i_rst_n, o_result_strobe, $past(busy))

    // An insert never reports a match count.
    `TPC_ASSERT_IMP(a_insert_zero, i_clk, i_rst_n, o_result_strobe && (o_done_operation == OP_INSERT), o_prefix_matches == '0)

    // At most one result per string.
    `TPC_ASSERT_NXT(a_no_double_strobe, i_clk, i_rst_n, o_result_strobe, !o_result_strobe)

    // A result is shown once the block is ready for the next beat.
    `TPC_ASSERT_IMP(a_strobe_idle, i_clk, i_rst_n, o_result_strobe, !busy)

endmodule

bind trie_prefix_count_core tpc_checker u_tpc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_result_strobe  (o_result_strobe),
    .o_done_operation (o_done_operation),
    .o_prefix_matches (o_prefix_matches)
);
